/* hw/rtl/ial_pkg.sv */
// ----------------------------------------------------------------------------
// ial_pkg: shared types and codes of the indexed array list
// Field widths, action and status codes, the sequencer states and the
// request and response transfer types used by every file of the block.
// ----------------------------------------------------------------------------
package ial_pkg;

    // Field widths fixed by the request and response formats.
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 12;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 13;

    // Default number of entries in the element store.
    localparam int CAPACITY_DEF = 4096;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHIFT,
        ST_DRAIN,
        ST_PUT,
        ST_DONE
    } state_t;

    // One request transfer.
    typedef struct packed {
        logic        [ACT_W-1:0]  action;
        logic        [IDX_W-1:0]  index;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // One response transfer.
    typedef struct packed {
        logic        [STAT_W-1:0] status;
        logic signed [DATA_W-1:0] data;
        logic        [CNT_W-1:0]  count;
    } rsp_t;

endpackage

/* hw/rtl/ial_store.sv */
// ----------------------------------------------------------------------------
// ial_store: element store of the indexed array list
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module ial_store #(
    parameter int AW = 12,
    parameter int DW = ial_pkg::DATA_W
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [DW-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic signed [DW-1:0] rdata
);

    logic signed [DW-1:0] mem [2**AW];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/indexed_array_list_top.sv */
// ----------------------------------------------------------------------------
// indexed_array_list_top: ordered list of signed 32-bit values
// Append, insert, remove, set and get on a fixed-capacity list, with the
// element shifting done one entry per cycle through the store's two ports.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req (req_valid / req_stall), one transfer per action;
// each request yields exactly one response on rsp (rsp_valid / rsp_stall)
// carrying status, data and the element count after the request.
// The block takes one request at a time: req_stall is high from the
// transfer until the response has been placed in the output register.
// With n = count - index, an insert moves n elements up and then writes the
// new value; a remove of an earlier element moves n - 1 elements down, and
// a remove of the last element moves none.
// The shift rate is set by the store: one read and one write per cycle.
// A new request is taken at the earliest in the cycle after the response
// is loaded.
// When the receiver stalls, the response waits in the output register and
// the next request is still taken; a second finished result waits in the
// sequencer until the register frees up.
// Reset empties the list and clears the response valid; the store itself
// is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module indexed_array_list_top #(
    parameter int CAPACITY = ial_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ial_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ial_pkg::rsp_t rsp
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ial_pkg::IDX_W) ? CW : ial_pkg::IDX_W;

    ial_pkg::state_t state_reg, state_next;

    logic [ial_pkg::ACT_W-1:0]         act_reg, act_next;
    logic [AW-1:0]                     addr_reg, addr_next;
    logic signed [ial_pkg::DATA_W-1:0] val_reg, val_next;
    logic [ial_pkg::STAT_W-1:0]        stat_reg, stat_next;
    logic signed [ial_pkg::DATA_W-1:0] data_reg, data_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [AW-1:0]                     ptr_reg, ptr_next;
    logic [AW-1:0]                     end_reg, end_next;
    logic                              up_reg, up_next;
    logic                              more_reg, more_next;
    logic                              wpend_reg, wpend_next;
    logic [AW-1:0]                     waddr_reg, waddr_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    ial_pkg::rsp_t                     rsp_reg, rsp_next;

    logic                              req_fire;
    logic                              rsp_fire;
    logic                              rsp_load;
    logic [CMPW-1:0]                   idx_ext;
    logic [CMPW-1:0]                   cnt_ext;
    logic [AW-1:0]                     idx_addr;
    logic                              full;
    logic                              empty;
    logic                              in_range;
    logic                              last_elem;
    logic [ial_pkg::STAT_W-1:0]        dec_status;
    logic [AW-1:0]                     ptr_step;
    logic [AW-1:0]                     ptr_dest;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [ial_pkg::DATA_W-1:0] mem_wdata;
    logic [AW-1:0]                     mem_raddr;
    logic signed [ial_pkg::DATA_W-1:0] mem_rdata;

    // Element store.
    ial_store #(
        .AW (AW),
        .DW (ial_pkg::DATA_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshake terms.
    assign req_stall = (state_reg != ial_pkg::ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_fire  = rsp_valid_reg && !rsp_stall;
    assign rsp_load  = (state_reg == ial_pkg::ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Request decode against the current count.
    assign idx_ext   = CMPW'(req.index);
    assign cnt_ext   = CMPW'(count_reg);
    assign idx_addr  = AW'(idx_ext);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign in_range  = (idx_ext < cnt_ext);
    assign last_elem = ((idx_ext + CMPW'(1)) == cnt_ext);

    always_comb
    begin
        unique case (req.action)
            ial_pkg::ACT_APPEND:
            begin
                dec_status = full ? ial_pkg::STAT_FULL : ial_pkg::STAT_OK;
            end
            ial_pkg::ACT_INSERT:
            begin
                if (full)
                    dec_status = ial_pkg::STAT_FULL;
                else if (!in_range)
                    dec_status = ial_pkg::STAT_RANGE;
                else
                    dec_status = ial_pkg::STAT_OK;
            end
            ial_pkg::ACT_REMOVE:
            begin
                if (empty)
                    dec_status = ial_pkg::STAT_EMPTY;
                else if (!in_range)
                    dec_status = ial_pkg::STAT_RANGE;
                else
                    dec_status = ial_pkg::STAT_OK;
            end
            ial_pkg::ACT_SET, ial_pkg::ACT_GET:
            begin
                dec_status = in_range ? ial_pkg::STAT_OK : ial_pkg::STAT_RANGE;
            end
            default:
            begin
                dec_status = ial_pkg::STAT_OK;
            end
        endcase
    end

    // Shared pointer unit: next read position and destination of the
    // element read at the current position.
    assign ptr_step = up_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
    assign ptr_dest = up_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ial_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (dec_status != ial_pkg::STAT_OK)
                        state_next = ial_pkg::ST_DONE;
                    else if (req.action == ial_pkg::ACT_INSERT)
                        state_next = ial_pkg::ST_SHIFT;
                    else if (req.action == ial_pkg::ACT_REMOVE ||
                             req.action == ial_pkg::ACT_SET ||
                             req.action == ial_pkg::ACT_GET)
                        state_next = ial_pkg::ST_FETCH;
                    else
                        state_next = ial_pkg::ST_DONE;
                end
            end
            ial_pkg::ST_FETCH:
            begin
                if (act_reg == ial_pkg::ACT_REMOVE && more_reg)
                    state_next = ial_pkg::ST_SHIFT;
                else
                    state_next = ial_pkg::ST_DONE;
            end
            ial_pkg::ST_SHIFT:
            begin
                if (ptr_reg == end_reg)
                    state_next = ial_pkg::ST_DRAIN;
            end
            ial_pkg::ST_DRAIN:
            begin
                state_next = up_reg ? ial_pkg::ST_PUT : ial_pkg::ST_DONE;
            end
            ial_pkg::ST_PUT:
            begin
                state_next = ial_pkg::ST_DONE;
            end
            ial_pkg::ST_DONE:
            begin
                if (rsp_load)
                    state_next = ial_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ial_pkg::ST_IDLE;
            end
        endcase
    end

    // Store port control from the sequencer state.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = waddr_reg;
        mem_wdata = mem_rdata;
        mem_raddr = ptr_reg;
        unique case (state_reg)
            ial_pkg::ST_IDLE:
            begin
                mem_raddr = idx_addr;
                mem_waddr = AW'(count_reg);
                mem_wdata = req.value;
                mem_we    = req_fire && (req.action == ial_pkg::ACT_APPEND) &&
                            (dec_status == ial_pkg::STAT_OK);
            end
            ial_pkg::ST_FETCH:
            begin
                mem_waddr = addr_reg;
                mem_wdata = val_reg;
                mem_we    = (act_reg == ial_pkg::ACT_SET);
            end
            ial_pkg::ST_SHIFT, ial_pkg::ST_DRAIN:
            begin
                mem_we = wpend_reg;
            end
            ial_pkg::ST_PUT:
            begin
                mem_waddr = addr_reg;
                mem_wdata = val_reg;
                mem_we    = 1'b1;
            end
            ial_pkg::ST_DONE:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        act_next       = act_reg;
        addr_next      = addr_reg;
        val_next       = val_reg;
        stat_next      = stat_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        more_next      = more_reg;
        wpend_next     = wpend_reg;
        waddr_next     = waddr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        // Latch the request and settle its status and the new count.
        if (req_fire)
        begin
            act_next   = req.action;
            addr_next  = idx_addr;
            val_next   = req.value;
            stat_next  = dec_status;
            data_next  = '0;
            wpend_next = 1'b0;
            more_next  = !last_elem;
            if (req.action == ial_pkg::ACT_INSERT)
            begin
                up_next  = 1'b1;
                ptr_next = AW'(count_reg - CW'(1));
                end_next = idx_addr;
            end
            else
            begin
                up_next  = 1'b0;
                ptr_next = AW'(idx_ext + CMPW'(1));
                end_next = AW'(count_reg - CW'(1));
            end
            if (dec_status == ial_pkg::STAT_OK)
            begin
                if (req.action == ial_pkg::ACT_APPEND ||
                    req.action == ial_pkg::ACT_INSERT)
                    count_next = count_reg + CW'(1);
                else if (req.action == ial_pkg::ACT_REMOVE)
                    count_next = count_reg - CW'(1);
            end
        end

        // Capture the element at the requested index.
        if (state_reg == ial_pkg::ST_FETCH)
        begin
            data_next = mem_rdata;
        end

        // One element moves per cycle: read here, written in the following cycle.
        if (state_reg == ial_pkg::ST_SHIFT)
        begin
            ptr_next   = ptr_step;
            waddr_next = ptr_dest;
            wpend_next = 1'b1;
        end
        else if (state_reg == ial_pkg::ST_DRAIN)
        begin
            wpend_next = 1'b0;
        end

        // Output register.
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.status = stat_reg;
            rsp_next.data   = data_reg;
            rsp_next.count  = ial_pkg::CNT_W'(count_reg);
        end
        else if (rsp_fire)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ial_pkg::ST_IDLE;
            count_reg     <= '0;
            wpend_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wpend_reg     <= wpend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        addr_reg  <= addr_next;
        val_reg   <= val_next;
        stat_reg  <= stat_next;
        data_reg  <= data_next;
        ptr_reg   <= ptr_next;
        end_reg   <= end_next;
        up_reg    <= up_next;
        more_reg  <= more_next;
        waddr_reg <= waddr_next;
        rsp_reg   <= rsp_next;
    end

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // The count changes only at a request transfer.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ial_pkg::ST_IDLE) |=> $stable(count_reg))
        else $error("element count changed while busy");

    // Shift writes stay inside the list.
    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ial_pkg::ST_SHIFT || state_reg == ial_pkg::ST_DRAIN) && wpend_reg)
        |-> (CW'(waddr_reg) < count_reg))
        else $error("shift write outside the list");

    // A response is loaded only from the finishing state.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ial_pkg::ST_DONE))
        else $error("response loaded outside the finishing state");

endmodule

/* tb/indexed_array_list_top_test.sv */
// ----------------------------------------------------------------------------
// indexed_array_list_top_test: self-checking bench of the indexed array list
// Drives list requests through the valid/stall handshake and scores every
// response against an in-bench list model or a typed row expectation: a
// directed table first, then random traffic under three idling regimes.
// ----------------------------------------------------------------------------
module indexed_array_list_top_test;

    // Bench constants.
    localparam int LIST_CAP    = ial_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 64;

    // Action codes the block ignores.
    localparam logic [ial_pkg::ACT_W-1:0] ACT_SPARE5 = 3'd5;
    localparam logic [ial_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ial_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;

    // Value extremes and all-ones.
    localparam logic signed [ial_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ial_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ial_pkg::DATA_W-1:0] VAL_NEG = 32'shFFFF_FFFF;

    // One row of the directed table.
    typedef struct packed {
        ial_pkg::req_t item;
        logic          typed;
        ial_pkg::rsp_t want;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    ial_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    ial_pkg::rsp_t rsp;

    // List model state.
    logic signed [ial_pkg::DATA_W-1:0] list_mem [LIST_CAP];
    int                                list_len;

    // Responses still owed by the block, oldest first.
    ial_pkg::rsp_t pending_rsp [$];
    row_t          plan_q [$];

    int errors;
    int send_idle;
    int recv_idle;
    int hold_ask;

    indexed_array_list_top #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the list model and return the response it owes.
    function automatic ial_pkg::rsp_t list_apply(ial_pkg::req_t r);
        ial_pkg::rsp_t res;
        int            idx;
        int            i;
        res = '0;
        idx = int'(r.index);
        case (r.action)
            ial_pkg::ACT_APPEND:
            begin
                if (list_len >= LIST_CAP)
                    res.status = ial_pkg::STAT_FULL;
                else
                begin
                    list_mem[list_len] = r.value;
                    list_len++;
                end
            end
            ial_pkg::ACT_INSERT:
            begin
                // A full list is reported before a bad index.
                if (list_len >= LIST_CAP)
                    res.status = ial_pkg::STAT_FULL;
                else if (idx >= list_len)
                    res.status = ial_pkg::STAT_RANGE;
                else
                begin
                    for (i = list_len; i > idx; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[idx] = r.value;
                    list_len++;
                end
            end
            ial_pkg::ACT_REMOVE:
            begin
                // An empty list is reported before a bad index.
                if (list_len == 0)
                    res.status = ial_pkg::STAT_EMPTY;
                else if (idx >= list_len)
                    res.status = ial_pkg::STAT_RANGE;
                else
                begin
                    res.data = list_mem[idx];
                    for (i = idx; i < list_len - 1; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            ial_pkg::ACT_SET:
            begin
                if (idx >= list_len)
                    res.status = ial_pkg::STAT_RANGE;
                else
                begin
                    res.data = list_mem[idx];
                    list_mem[idx] = r.value;
                end
            end
            ial_pkg::ACT_GET:
            begin
                if (idx >= list_len)
                    res.status = ial_pkg::STAT_RANGE;
                else
                    res.data = list_mem[idx];
            end
            default:
            begin
                // Spare actions leave the list alone.
            end
        endcase
        res.count = ial_pkg::CNT_W'(list_len);
        return res;
    endfunction

    function automatic ial_pkg::req_t make_req(logic [ial_pkg::ACT_W-1:0] act, int idx,
                                               logic signed [ial_pkg::DATA_W-1:0] val);
        ial_pkg::req_t r;
        r.action = act;
        r.index  = ial_pkg::IDX_W'(idx);
        r.value  = val;
        return r;
    endfunction

    function automatic ial_pkg::rsp_t make_rsp(logic [ial_pkg::STAT_W-1:0] st,
                                               logic signed [ial_pkg::DATA_W-1:0] dat,
                                               int cnt);
        ial_pkg::rsp_t r;
        r.status = st;
        r.data   = dat;
        r.count  = ial_pkg::CNT_W'(cnt);
        return r;
    endfunction

    task automatic add_row(ial_pkg::req_t item, logic typed, ial_pkg::rsp_t want);
        row_t row;
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        plan_q.push_back(row);
    endtask

    // Offer one request, hold it until the transfer, then log what it owes.
    // A typed expectation replaces the model's answer for that row.
    task automatic send_item(ial_pkg::req_t r, logic typed, ial_pkg::rsp_t want);
        ial_pkg::rsp_t guess;
        while (send_idle != 0 && $urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        guess = list_apply(r);
        pending_rsp.push_back(typed ? want : guess);
    endtask

    // Stop offering and wait until every owed response has arrived.
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Random traffic: mostly in-range list operations with random content,
    // biased to keep the list short, plus stray indexes and spare actions.
    task automatic run_random(int n);
        ial_pkg::req_t r;
        int            len;
        int            pick;
        int            grow;
        int            k;
        repeat (n)
        begin
            len  = list_len;
            pick = $urandom_range(0, 99);
            grow = (len < 8) ? 30 : ((len > 48) ? 5 : 15);
            case ($urandom_range(0, 15))
                0:       r.value = VAL_MAX;
                1:       r.value = VAL_MIN;
                2:       r.value = '0;
                default: r.value = $urandom;
            endcase
            k = $urandom_range(0, 9);
            if (len == 0 || k == 0)
                r.index = ial_pkg::IDX_W'($urandom_range(0, 4095));
            else if (k == 1)
                r.index = ial_pkg::IDX_W'(len);
            else
                r.index = ial_pkg::IDX_W'($urandom_range(0, len - 1));
            if (pick < 4)
                r.action = ial_pkg::ACT_W'($urandom_range(ACT_SPARE5, ACT_SPARE7));
            else if (pick < 4 + grow)
                r.action = ial_pkg::ACT_APPEND;
            else if (pick < 4 + 2 * grow)
                r.action = ial_pkg::ACT_INSERT;
            else if (pick < 70)
                r.action = ial_pkg::ACT_REMOVE;
            else if (pick < 85)
                r.action = ial_pkg::ACT_SET;
            else
                r.action = ial_pkg::ACT_GET;
            send_item(r, 1'b0, '0);
        end
    endtask

    // Response side: score each transfer and stall at random or on request.
    initial
    begin : rsp_side
        int            hold_left;
        ial_pkg::rsp_t want;
        hold_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response, expected none, got %0d/%0d/%0d",
                             $time, rsp.status, rsp.data, rsp.count);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (rsp.data !== want.data)
                    begin
                        errors++;
                        $display("%0t: data mismatch, expected %0d, got %0d",
                                 $time, want.data, rsp.data);
                    end
                    if (rsp.count !== want.count)
                    begin
                        errors++;
                        $display("%0t: count mismatch, expected %0d, got %0d",
                                 $time, want.count, rsp.count);
                    end
                end
            end
            // A long hold-off is counted here so the sender keeps pushing.
            if (hold_ask != 0)
            begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= (recv_idle != 0) && ($urandom_range(0, 99) < recv_idle);
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
        $display("indexed_array_list_top_test failed");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        errors    = 0;
        list_len  = 0;
        hold_ask  = 0;
        send_idle = 20;
        recv_idle = 47;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty-list errors and spare actions, value extremes, inserts
        // at the first and last index and past the end, set and get, removes at both ends and past the end.
        add_row(make_req(ial_pkg::ACT_GET, 0, '0), 1'b1,
                make_rsp(ial_pkg::STAT_RANGE, '0, 0));
        add_row(make_req(ial_pkg::ACT_REMOVE, 0, '0), 1'b1,
                make_rsp(ial_pkg::STAT_EMPTY, '0, 0));
        add_row(make_req(ial_pkg::ACT_REMOVE, 4095, VAL_NEG), 1'b1,
                make_rsp(ial_pkg::STAT_EMPTY, '0, 0));
        add_row(make_req(ial_pkg::ACT_INSERT, 0, 32'sd5), 1'b1,
                make_rsp(ial_pkg::STAT_RANGE, '0, 0));
        add_row(make_req(ial_pkg::ACT_SET, 4095, VAL_NEG), 1'b1,
                make_rsp(ial_pkg::STAT_RANGE, '0, 0));
        add_row(make_req(ACT_SPARE5, 4095, VAL_MAX), 1'b1,
                make_rsp(ial_pkg::STAT_OK, '0, 0));
        add_row(make_req(ACT_SPARE7, 0, VAL_NEG), 1'b1,
                make_rsp(ial_pkg::STAT_OK, '0, 0));
        add_row(make_req(ial_pkg::ACT_APPEND, 4095, VAL_MAX), 1'b1,
                make_rsp(ial_pkg::STAT_OK, '0, 1));
        add_row(make_req(ial_pkg::ACT_APPEND, 0, VAL_MIN), 1'b1,
                make_rsp(ial_pkg::STAT_OK, '0, 2));
        add_row(make_req(ial_pkg::ACT_APPEND, 0, VAL_NEG), 1'b1,
                make_rsp(ial_pkg::STAT_OK, '0, 3));
        add_row(make_req(ial_pkg::ACT_GET, 0, '0), 1'b1,
                make_rsp(ial_pkg::STAT_OK, VAL_MAX, 3));
        add_row(make_req(ial_pkg::ACT_GET, 3, '0), 1'b1,
                make_rsp(ial_pkg::STAT_RANGE, '0, 3));
        add_row(make_req(ial_pkg::ACT_INSERT, 0, '0), 1'b0, '0);
        add_row(make_req(ial_pkg::ACT_INSERT, 3, 32'sh1234_5678), 1'b0, '0);
        add_row(make_req(ial_pkg::ACT_INSERT, 5, VAL_MIN), 1'b1,
                make_rsp(ial_pkg::STAT_RANGE, '0, 5));
        add_row(make_req(ial_pkg::ACT_SET, 1, 32'sh5A5A_5A5A), 1'b0, '0);
        add_row(make_req(ial_pkg::ACT_GET, 1, '0), 1'b0, '0);
        add_row(make_req(ial_pkg::ACT_SET, 4095, VAL_MAX), 1'b1,
                make_rsp(ial_pkg::STAT_RANGE, '0, 5));
        add_row(make_req(ial_pkg::ACT_REMOVE, 4, '0), 1'b0, '0);
        add_row(make_req(ial_pkg::ACT_REMOVE, 0, '0), 1'b0, '0);
        add_row(make_req(ial_pkg::ACT_REMOVE, 3, '0), 1'b1,
                make_rsp(ial_pkg::STAT_RANGE, '0, 3));
        add_row(make_req(ACT_SPARE6, 2, VAL_MIN), 1'b1,
                make_rsp(ial_pkg::STAT_OK, '0, 3));
        add_row(make_req(ial_pkg::ACT_GET, 2, '0), 1'b0, '0);
        add_row(make_req(ial_pkg::ACT_REMOVE, 1, '0), 1'b0, '0);
        foreach (plan_q[i])
            send_item(plan_q[i].item, plan_q[i].typed, plan_q[i].want);

        // Sender pauses until the block has answered everything.
        settle();
        run_random(30);

        // Swap the idling of the two sides; hold the receiver off for a long
        // stretch while requests keep coming so the block backs up.
        send_idle = 47;
        recv_idle = 20;
        hold_ask  = HOLD_CYCLES;
        run_random(10);
        run_random(35);
        settle();

        // No idling from here on.
        send_idle = 0;
        recv_idle = 0;
        run_random(40);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("indexed_array_list_top_test passed");
        else
            $display("indexed_array_list_top_test failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ial_pkg.sv
hw/rtl/ial_store.sv
hw/rtl/indexed_array_list_top.sv
tb/indexed_array_list_top_test.sv
